// ===== src/cau_pkg.sv =====
// Shared constants, types and the arctangent table of the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int IO_W          = 32;
  localparam int CORDIC_STEPS  = 30;
  localparam int ANGLE_W       = 34;   // Q30 angle plus headroom for the pi turn

  localparam logic signed [ANGLE_W-1:0] PI_Q30 = 34'sd3373259426;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_MAG = 3'd4;
  localparam logic [2:0] MODE_ANG = 3'd5;
  localparam logic [2:0] MODE_EQ  = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // control that travels alongside the data through the cell chain
  typedef struct packed {
    logic [2:0] mode;
    logic       equal;
    logic       skip;     // angle fixed up front, rotations idle
    logic       divz;
    logic       ovf_re;   // quotient known to overflow
    logic       ovf_im;
    logic       neg_re;
    logic       neg_im;
  } ctl_t;

  // one result word
  typedef struct packed {
    logic signed [IO_W-1:0] res_re;
    logic signed [IO_W-1:0] res_im;
    logic                   equal;
    logic [1:0]             status;
  } word_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd843314857;
      1:       r = 32'd497837829;
      2:       r = 32'd263043837;
      3:       r = 32'd133525159;
      4:       r = 32'd67021687;
      5:       r = 32'd33543516;
      6:       r = 32'd16775851;
      7:       r = 32'd8388437;
      8:       r = 32'd4194283;
      9:       r = 32'd2097149;
      default: r = 32'd1 << (30 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== src/cau_front.sv =====
// Front end: operand capture, products, sums and set-up of the cell chain.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    i_valid,
  input  logic [2:0]                              i_mode,
  input  logic signed [cau_pkg::IO_W-1:0]         i_a_re,
  input  logic signed [cau_pkg::IO_W-1:0]         i_a_im,
  input  logic signed [cau_pkg::IO_W-1:0]         i_b_re,
  input  logic signed [cau_pkg::IO_W-1:0]         i_b_im,
  output logic                                    o_valid,
  output cau_pkg::ctl_t                           o_ctl,
  output logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_rem_re,
  output logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_rem_im,
  output logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_dvs,
  output logic signed [((WORD_BITS < 32) ? WORD_BITS : 32)+2:0] o_cx,
  output logic signed [((WORD_BITS < 32) ? WORD_BITS : 32)+2:0] o_cy,
  output logic signed [cau_pkg::ANGLE_W-1:0]      o_cz
);

  localparam int EW = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW = 2 * EW;
  localparam int XW = PW + cau_pkg::max_int(FRAC_BITS, EW);
  localparam int CW = EW + 3;
  localparam int ZW = cau_pkg::ANGLE_W;
  localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

  // stage 1: captured operands
  logic                 v1;
  logic [2:0]           m1;
  logic signed [EW-1:0] ar1, ai1, br1, bi1;

  // stage 2: products
  logic                 v2;
  logic [2:0]           m2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq0, sq1;
  logic signed [EW:0]   as2_re, as2_im;
  logic                 eq2, bz2, skip2;
  logic signed [CW-1:0] cx2, cy2;
  logic signed [ZW-1:0] cz2;

  // stage 3: sums
  logic                 v3;
  logic [2:0]           m3;
  logic signed [PW:0]   r3, i3;
  logic [PW-1:0]        den3;
  logic signed [EW:0]   as3_re, as3_im;
  logic                 eq3, bz3, skip3;
  logic signed [CW-1:0] cx3, cy3;
  logic signed [ZW-1:0] cz3;

  logic signed [EW-1:0] u0, u1;
  logic                 y0, xneg;
  logic signed [PW:0]   mre, mim, dre, dim;

  logic [PW:0]          mag_r, mag_i, mul_r, mul_i;
  logic [EW:0]          amag_re, amag_im;
  logic [XW-1:0]        num_re, num_im, den_sh;
  cau_pkg::ctl_t        c4;
  logic [XW-1:0]        rre4, rim4;

  assign u0   = (m1 == cau_pkg::MODE_MAG) ? ar1 : br1;
  assign u1   = (m1 == cau_pkg::MODE_MAG) ? ai1 : bi1;
  assign y0   = (ai1 == '0);
  assign xneg = ar1[EW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1 <= i_valid;
      v2 <= v1;
      v3 <= v2;
      o_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= i_mode;
      ar1 <= i_a_re[EW-1:0];
      ai1 <= i_a_im[EW-1:0];
      br1 <= i_b_re[EW-1:0];
      bi1 <= i_b_im[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2   <= m1;
      p_rr <= ar1 * br1;
      p_ii <= ai1 * bi1;
      p_ri <= ar1 * bi1;
      p_ir <= ai1 * br1;
      sq0  <= u0 * u0;
      sq1  <= u1 * u1;
      if (m1 == cau_pkg::MODE_SUB) begin
        as2_re <= (EW+1)'(ar1) - (EW+1)'(br1);
        as2_im <= (EW+1)'(ai1) - (EW+1)'(bi1);
      end else begin
        as2_re <= (EW+1)'(ar1) + (EW+1)'(br1);
        as2_im <= (EW+1)'(ai1) + (EW+1)'(bi1);
      end
      eq2   <= (ar1 == br1) && (ai1 == bi1);
      bz2   <= (br1 == '0) && (bi1 == '0);
      skip2 <= y0;
      // left half plane: turn by pi before the rotations
      if (xneg && !y0) begin
        cx2 <= -CW'(ar1);
        cy2 <= -CW'(ai1);
      end else begin
        cx2 <= CW'(ar1);
        cy2 <= CW'(ai1);
      end
      if (!xneg)
        cz2 <= '0;
      else if (y0 || !ai1[EW-1])
        cz2 <= cau_pkg::PI_Q30;
      else
        cz2 <= -cau_pkg::PI_Q30;
    end
  end

  assign mre = (PW+1)'(p_rr) - (PW+1)'(p_ii);
  assign mim = (PW+1)'(p_ri) + (PW+1)'(p_ir);
  assign dre = (PW+1)'(p_rr) + (PW+1)'(p_ii);
  assign dim = (PW+1)'(p_ir) - (PW+1)'(p_ri);

  always_ff @(posedge clk) begin
    if (en) begin
      m3     <= m2;
      r3     <= (m2 == cau_pkg::MODE_DIV) ? dre : mre;
      i3     <= (m2 == cau_pkg::MODE_DIV) ? dim : mim;
      den3   <= $unsigned(sq0) + $unsigned(sq1);
      as3_re <= as2_re;
      as3_im <= as2_im;
      eq3    <= eq2;
      bz3    <= bz2;
      skip3  <= skip2;
      cx3    <= cx2;
      cy3    <= cy2;
      cz3    <= cz2;
    end
  end

  // stage 4: sign/magnitude, product rounding, quotient range check
  assign mag_r   = r3[PW] ? $unsigned(-r3) : $unsigned(r3);
  assign mag_i   = i3[PW] ? $unsigned(-i3) : $unsigned(i3);
  assign mul_r   = (mag_r + HALF) >> FRAC_BITS;
  assign mul_i   = (mag_i + HALF) >> FRAC_BITS;
  assign amag_re = as3_re[EW] ? $unsigned(-as3_re) : $unsigned(as3_re);
  assign amag_im = as3_im[EW] ? $unsigned(-as3_im) : $unsigned(as3_im);
  assign num_re  = XW'(mag_r) << FRAC_BITS;
  assign num_im  = XW'(mag_i) << FRAC_BITS;
  assign den_sh  = XW'(den3) << EW;

  always_comb begin
    c4       = '0;
    c4.mode  = m3;
    c4.equal = eq3;
    c4.skip  = skip3;
    rre4     = '0;
    rim4     = '0;
    unique case (m3) inside
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
        rre4      = XW'(amag_re);
        rim4      = XW'(amag_im);
        c4.neg_re = as3_re[EW];
        c4.neg_im = as3_im[EW];
      end
      cau_pkg::MODE_MUL: begin
        rre4      = XW'(mul_r);
        rim4      = XW'(mul_i);
        c4.neg_re = r3[PW];
        c4.neg_im = i3[PW];
      end
      cau_pkg::MODE_DIV: begin
        rre4      = num_re;
        rim4      = num_im;
        c4.neg_re = r3[PW];
        c4.neg_im = i3[PW];
        c4.divz   = bz3;
        c4.ovf_re = (num_re >= den_sh);
        c4.ovf_im = (num_im >= den_sh);
      end
      cau_pkg::MODE_MAG: begin
        rre4 = XW'(den3);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_ctl    <= c4;
      o_rem_re <= rre4;
      o_rem_im <= rim4;
      o_dvs    <= den_sh;
      o_cx     <= cx3;
      o_cy     <= cy3;
      o_cz     <= cz3;
    end
  end

endmodule

// ===== src/cau_cell.sv =====
// One cell of the chain: a quotient bit, a root bit or a rotation per cycle while en is high.
module cau_cell #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    i_valid,
  input  cau_pkg::ctl_t                           i_ctl,
  input  logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_rem_re,
  input  logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_rem_im,
  input  logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_dvs,
  input  logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_q_re,
  input  logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_q_im,
  input  logic signed [((WORD_BITS < 32) ? WORD_BITS : 32)+2:0] i_cx,
  input  logic signed [((WORD_BITS < 32) ? WORD_BITS : 32)+2:0] i_cy,
  input  logic signed [cau_pkg::ANGLE_W-1:0]      i_cz,
  output logic                                    o_valid,
  output cau_pkg::ctl_t                           o_ctl,
  output logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_rem_re,
  output logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_rem_im,
  output logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_dvs,
  output logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_q_re,
  output logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] o_q_im,
  output logic signed [((WORD_BITS < 32) ? WORD_BITS : 32)+2:0] o_cx,
  output logic signed [((WORD_BITS < 32) ? WORD_BITS : 32)+2:0] o_cy,
  output logic signed [cau_pkg::ANGLE_W-1:0]      o_cz
);

  localparam int EW     = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW     = 2 * EW;
  localparam int XW     = PW + cau_pkg::max_int(FRAC_BITS, EW);
  localparam int CW     = EW + 3;
  localparam int ZW     = cau_pkg::ANGLE_W;
  localparam bit DIV_ON = (IDX < EW);
  localparam bit ROT_ON = (IDX < cau_pkg::CORDIC_STEPS);
  localparam int BITPOS = DIV_ON ? (PW - 2 - 2 * IDX) : 0;
  localparam int SH_R   = ROT_ON ? IDX : 0;
  localparam logic [XW-1:0]        ROOT_BIT = XW'(1) << BITPOS;
  localparam logic signed [ZW-1:0] ATAN     = ZW'(cau_pkg::atan_step(SH_R));

  logic [XW-1:0]        dd, t_sq;
  logic                 ge_re, ge_im;
  logic signed [CW-1:0] dx, dy;

  logic [XW-1:0]        rem_re_next, rem_im_next, dvs_next;
  logic [EW-1:0]        q_re_next, q_im_next;
  logic signed [CW-1:0] cx_next, cy_next;
  logic signed [ZW-1:0] cz_next;

  assign dd    = i_dvs >> 1;
  assign ge_re = (i_rem_re >= dd);
  assign ge_im = (i_rem_im >= dd);
  assign t_sq  = i_rem_im + ROOT_BIT;
  assign dx    = i_cx >>> SH_R;
  assign dy    = i_cy >>> SH_R;

  always_comb begin
    rem_re_next = i_rem_re;
    rem_im_next = i_rem_im;
    dvs_next    = i_dvs;
    q_re_next   = i_q_re;
    q_im_next   = i_q_im;
    cx_next     = i_cx;
    cy_next     = i_cy;
    cz_next     = i_cz;
    unique case (i_ctl.mode) inside
      cau_pkg::MODE_DIV: begin
        if (DIV_ON) begin
          // restoring step, both parts share the divisor
          dvs_next  = dd;
          q_re_next = {i_q_re[EW-2:0], ge_re};
          q_im_next = {i_q_im[EW-2:0], ge_im};
          if (ge_re) rem_re_next = i_rem_re - dd;
          if (ge_im) rem_im_next = i_rem_im - dd;
        end
      end
      cau_pkg::MODE_MAG: begin
        // radicand in rem_re, partial root in rem_im
        if (DIV_ON) begin
          if (i_rem_re >= t_sq) begin
            rem_re_next = i_rem_re - t_sq;
            rem_im_next = (i_rem_im >> 1) + ROOT_BIT;
          end else begin
            rem_im_next = i_rem_im >> 1;
          end
        end
      end
      cau_pkg::MODE_ANG: begin
        if (ROT_ON && !i_ctl.skip) begin
          if (!i_cy[CW-1]) begin
            cx_next = i_cx + dy;
            cy_next = i_cy - dx;
            cz_next = i_cz + ATAN;
          end else begin
            cx_next = i_cx - dy;
            cy_next = i_cy + dx;
            cz_next = i_cz - ATAN;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_ctl    <= i_ctl;
      o_rem_re <= rem_re_next;
      o_rem_im <= rem_im_next;
      o_dvs    <= dvs_next;
      o_q_re   <= q_re_next;
      o_q_im   <= q_im_next;
      o_cx     <= cx_next;
      o_cy     <= cy_next;
      o_cz     <= cz_next;
    end
  end

endmodule

// ===== src/cau_finish.sv =====
// Back end: final rounding, saturation and status.
module cau_finish #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    i_valid,
  input  cau_pkg::ctl_t                           i_ctl,
  input  logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_rem_re,
  input  logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_rem_im,
  input  logic [2*((WORD_BITS < 32) ? WORD_BITS : 32)
               + cau_pkg::max_int(FRAC_BITS, (WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_dvs,
  input  logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_q_re,
  input  logic [((WORD_BITS < 32) ? WORD_BITS : 32)-1:0] i_q_im,
  input  logic signed [cau_pkg::ANGLE_W-1:0]      i_cz,
  output logic                                    o_valid,
  output cau_pkg::word_t                          o_word
);

  localparam int EW = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW = 2 * EW;
  localparam int XW = PW + cau_pkg::max_int(FRAC_BITS, EW);
  localparam int MW = PW + 1;
  localparam int ZW = cau_pkg::ANGLE_W;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [ZW-1:0]        HALF_A = (ZW'(1) << SH) >> 1;
  localparam logic [MW-1:0]        LIM    = MW'(1) << (EW - 1);
  localparam logic signed [EW-1:0] MAXV   = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] MINV   = {1'b1, {(EW-1){1'b0}}};

  logic          rnd_re, rnd_im;
  logic [MW-1:0] root;
  logic [ZW-1:0] zmag, amag;

  logic [MW-1:0] mre_next, mim_next;
  logic          nre_next, nim_next, fre_next, fim_next;

  // stage f1
  logic          v1, nre, nim, fre, fim, divz1, eq1;
  logic [MW-1:0] mre, mim;

  logic                 sat_re, sat_im;
  logic signed [EW-1:0] val_re, val_im;
  cau_pkg::word_t       w_next;

  assign rnd_re = ({i_rem_re, 1'b0} >= {1'b0, i_dvs});
  assign rnd_im = ({i_rem_im, 1'b0} >= {1'b0, i_dvs});
  assign root   = MW'(i_rem_im) + MW'(i_rem_re > i_rem_im);
  assign zmag   = i_cz[ZW-1] ? $unsigned(-i_cz) : $unsigned(i_cz);
  assign amag   = (zmag + HALF_A) >> SH;

  always_comb begin
    mre_next = '0;
    mim_next = '0;
    nre_next = 1'b0;
    nim_next = 1'b0;
    fre_next = 1'b0;
    fim_next = 1'b0;
    unique case (i_ctl.mode) inside
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL: begin
        mre_next = MW'(i_rem_re);
        mim_next = MW'(i_rem_im);
        nre_next = i_ctl.neg_re;
        nim_next = i_ctl.neg_im;
      end
      cau_pkg::MODE_DIV: begin
        if (!i_ctl.divz) begin
          mre_next = MW'(i_q_re) + MW'(rnd_re);
          mim_next = MW'(i_q_im) + MW'(rnd_im);
          nre_next = i_ctl.neg_re;
          nim_next = i_ctl.neg_im;
          fre_next = i_ctl.ovf_re;
          fim_next = i_ctl.ovf_im;
        end
      end
      cau_pkg::MODE_MAG: begin
        mre_next = root;
      end
      cau_pkg::MODE_ANG: begin
        mre_next = MW'(amag);
        nre_next = i_cz[ZW-1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1      <= i_valid;
      o_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mre   <= mre_next;
      mim   <= mim_next;
      nre   <= nre_next;
      nim   <= nim_next;
      fre   <= fre_next;
      fim   <= fim_next;
      divz1 <= (i_ctl.mode == cau_pkg::MODE_DIV) && i_ctl.divz;
      eq1   <= i_ctl.equal;
    end
  end

  // stage f2: clamp to the word range
  assign sat_re = fre || (nre ? (mre > LIM) : (mre > LIM - MW'(1)));
  assign sat_im = fim || (nim ? (mim > LIM) : (mim > LIM - MW'(1)));
  assign val_re = sat_re ? (nre ? MINV : MAXV) : (nre ? -mre[EW-1:0] : mre[EW-1:0]);
  assign val_im = sat_im ? (nim ? MINV : MAXV) : (nim ? -mim[EW-1:0] : mim[EW-1:0]);

  always_comb begin
    w_next.res_re = cau_pkg::IO_W'(val_re);
    w_next.res_im = cau_pkg::IO_W'(val_im);
    w_next.equal  = eq1;
    if (sat_re || sat_im)
      w_next.status = cau_pkg::ST_SAT;
    else if (divz1)
      w_next.status = cau_pkg::ST_DIVZ;
    else
      w_next.status = cau_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_word <= w_next;
    end
  end

endmodule

// ===== src/cau_outbuf.sv =====
// Output register with a skid entry; frees the pipeline from the receiver's stall.
module cau_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           i_valid,
  input  cau_pkg::word_t i_word,
  output logic           en,
  output logic           o_valid,
  input  logic           o_stall,
  output cau_pkg::word_t o_word
);

  logic           skid_v;
  cau_pkg::word_t skid_w;

  assign en = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      skid_v  <= 1'b0;
    end else if (!o_valid || !o_stall) begin
      if (skid_v) begin
        o_valid <= 1'b1;
        skid_v  <= 1'b0;
      end else begin
        o_valid <= i_valid;
      end
    end else if (!skid_v && i_valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || !o_stall) begin
      o_word <= skid_v ? skid_w : i_word;
    end else if (!skid_v) begin
      skid_w <= i_word;
    end
  end

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, sub, mul, div, magnitude, angle, equality on Q16.16 pairs.
// Input channel: in_valid/in_stall carry one word (mode, a_re, a_im, b_re, b_im); it is
// taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry one word (res_re, res_im, equal, status).
// Throughput: one word per cycle while in_stall is low, in any mix of modes.
// The pipeline length is set by the cell chain: each cell retires one quotient bit,
// one root bit or one CORDIC rotation.
// Stalls: a stalled result sits in the output register and one more word drops into
// the skid entry; only when that entry is full does in_stall rise and the whole
// pipeline hold. in_stall is a register, with no path from out_stall.
// Reset (rst, synchronous): empties the pipeline and both output entries; there is
// no stored state beyond the words in flight.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      mode,
  input  logic signed [cau_pkg::IO_W-1:0] a_re,
  input  logic signed [cau_pkg::IO_W-1:0] a_im,
  input  logic signed [cau_pkg::IO_W-1:0] b_re,
  input  logic signed [cau_pkg::IO_W-1:0] b_im,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [cau_pkg::IO_W-1:0] res_re,
  output logic signed [cau_pkg::IO_W-1:0] res_im,
  output logic                            equal,
  output logic [1:0]                      status
);

  // effective word width; operands wider than the port are not carried
  localparam int EW = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int PW = 2 * EW;
  localparam int XW = PW + cau_pkg::max_int(FRAC_BITS, EW);
  localparam int CW = EW + 3;
  localparam int ZW = cau_pkg::ANGLE_W;
  localparam int NC = cau_pkg::max_int(EW, cau_pkg::CORDIC_STEPS);

  logic en;

  // chain taps: entry 0 is the front end, entry NC feeds the finish stage
  logic                 v_c      [NC+1];
  cau_pkg::ctl_t        ctl_c    [NC+1];
  logic [XW-1:0]        rem_re_c [NC+1];
  logic [XW-1:0]        rem_im_c [NC+1];
  logic [XW-1:0]        dvs_c    [NC+1];
  logic [EW-1:0]        q_re_c   [NC+1];
  logic [EW-1:0]        q_im_c   [NC+1];
  logic signed [CW-1:0] cx_c     [NC+1];
  logic signed [CW-1:0] cy_c     [NC+1];
  logic signed [ZW-1:0] cz_c     [NC+1];

  logic           fin_v;
  cau_pkg::word_t fin_w;
  cau_pkg::word_t out_w;

  assign in_stall = !en;

  cau_front #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .i_valid  (in_valid),
    .i_mode   (mode),
    .i_a_re   (a_re),
    .i_a_im   (a_im),
    .i_b_re   (b_re),
    .i_b_im   (b_im),
    .o_valid  (v_c[0]),
    .o_ctl    (ctl_c[0]),
    .o_rem_re (rem_re_c[0]),
    .o_rem_im (rem_im_c[0]),
    .o_dvs    (dvs_c[0]),
    .o_cx     (cx_c[0]),
    .o_cy     (cy_c[0]),
    .o_cz     (cz_c[0])
  );

  // quotients are built up bit by bit in the chain
  assign q_re_c[0] = '0;
  assign q_im_c[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_cell #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS),
      .IDX       (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .i_valid  (v_c[k]),
      .i_ctl    (ctl_c[k]),
      .i_rem_re (rem_re_c[k]),
      .i_rem_im (rem_im_c[k]),
      .i_dvs    (dvs_c[k]),
      .i_q_re   (q_re_c[k]),
      .i_q_im   (q_im_c[k]),
      .i_cx     (cx_c[k]),
      .i_cy     (cy_c[k]),
      .i_cz     (cz_c[k]),
      .o_valid  (v_c[k+1]),
      .o_ctl    (ctl_c[k+1]),
      .o_rem_re (rem_re_c[k+1]),
      .o_rem_im (rem_im_c[k+1]),
      .o_dvs    (dvs_c[k+1]),
      .o_q_re   (q_re_c[k+1]),
      .o_q_im   (q_im_c[k+1]),
      .o_cx     (cx_c[k+1]),
      .o_cy     (cy_c[k+1]),
      .o_cz     (cz_c[k+1])
    );
  end

  // rounding, clamping and status
  cau_finish #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .i_valid  (v_c[NC]),
    .i_ctl    (ctl_c[NC]),
    .i_rem_re (rem_re_c[NC]),
    .i_rem_im (rem_im_c[NC]),
    .i_dvs    (dvs_c[NC]),
    .i_q_re   (q_re_c[NC]),
    .i_q_im   (q_im_c[NC]),
    .i_cz     (cz_c[NC]),
    .o_valid  (fin_v),
    .o_word   (fin_w)
  );

  // the final cx and cy taps of the chain are left unconnected
  cau_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .i_valid (fin_v),
    .i_word  (fin_w),
    .en      (en),
    .o_valid (out_valid),
    .o_stall (out_stall),
    .o_word  (out_w)
  );

  assign res_re = out_w.res_re;
  assign res_im = out_w.res_im;
  assign equal  = out_w.equal;
  assign status = out_w.status;

endmodule
